// File: rtl/ccc_pkg.sv
// Shared types, constants and decimal helpers for the clock and calendar counter.
`default_nettype none
package ccc_pkg;

  localparam int unsigned FIELD_W = 7;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned TEXT_W  = 64;

  // Command codes carried on the action field
  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET_TIME = 2'd1,
    ACT_SET_DATE = 2'd2
  } action_t;

  // Current time and date, passed between the counter and the formatter
  typedef struct packed {
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } clock_fields_t;

  localparam logic [7:0]        SEC_PER_MIN   = 8'd60;
  localparam logic [7:0]        MIN_PER_HOUR  = 8'd60;
  localparam logic [7:0]        HOUR_PER_DAY  = 8'd24;
  localparam logic [7:0]        MONTH_LAST    = 8'd12;
  localparam logic [YEAR_W-1:0] YEAR_LAST     = 14'd9999;
  localparam logic [YEAR_W-1:0] YEAR_SPAN     = 14'd10000;
  localparam logic [YEAR_W-1:0] RESET_YEAR    = 14'd1971;
  localparam logic [7:0]        ASCII_ZERO    = 8'd48;
  localparam logic [7:0]        POINT_MARK    = 8'd128;
  localparam logic [7:0]        SEPARATOR     = 8'd58;

  // Quotient by 100 through a reciprocal; exact for every 14-bit value
  function automatic logic [7:0] div100(input logic [YEAR_W-1:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'd5243;
    return p[26:19];
  endfunction

  // Two characters of a value below 128: tens (may pass '9') and units
  function automatic logic [15:0] two_digits(input logic [FIELD_W-1:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {ASCII_ZERO + 8'(tens), ASCII_ZERO + 8'(ones)};
  endfunction

  // Days in a month, Gregorian leap rule; zero for a month outside 1..12
  function automatic logic [4:0] month_length(input logic [FIELD_W-1:0] m,
                                              input logic [YEAR_W-1:0] y);
    logic [7:0]        q;
    logic [YEAR_W-1:0] r;
    logic              leap;
    logic [4:0]        len;
    q    = div100(y);
    r    = y - 14'(q) * 14'd100;
    leap = (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
    case (m) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ccc_calendar.sv
// Time and date registers with the second-to-year carry chain and set loads.
`default_nettype none
module ccc_calendar (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [1:0]                    action,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_hour,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_minute,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_second,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_day,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_month,
  input  wire logic [ccc_pkg::YEAR_W-1:0]    new_year,
  output ccc_pkg::clock_fields_t             fields
);
  import ccc_pkg::*;

  clock_fields_t     fields_next;
  logic [7:0]        sec_inc;
  logic [7:0]        min_inc;
  logic [7:0]        hour_inc;
  logic [7:0]        day_inc;
  logic [7:0]        mon_inc;
  logic              sec_wrap;
  logic              min_wrap;
  logic              hour_wrap;
  logic              day_over;
  logic              mon_over;
  logic [4:0]        days_in_month;
  clock_fields_t     ticked;

  // Run the carry chain; each stage checks its own range
  always_comb begin
    sec_inc       = {1'b0, fields.second} + 8'd1;
    sec_wrap      = sec_inc >= SEC_PER_MIN;
    min_inc       = {1'b0, fields.minute} + 8'(sec_wrap);
    min_wrap      = min_inc >= MIN_PER_HOUR;
    hour_inc      = {1'b0, fields.hour} + 8'(min_wrap);
    hour_wrap     = hour_inc >= HOUR_PER_DAY;
    days_in_month = month_length(fields.month, fields.year);
    day_inc       = {1'b0, fields.day} + 8'd1;
    day_over      = day_inc > {3'b000, days_in_month};
    mon_inc       = {1'b0, fields.month} + 8'(day_over);
    mon_over      = mon_inc > MONTH_LAST;

    ticked        = fields;
    ticked.second = sec_wrap ? '0 : sec_inc[FIELD_W-1:0];
    ticked.minute = min_wrap ? '0 : min_inc[FIELD_W-1:0];
    ticked.hour   = hour_wrap ? '0 : hour_inc[FIELD_W-1:0];
    if (hour_wrap) begin
      ticked.day   = day_over ? 7'd1 : day_inc[FIELD_W-1:0];
      ticked.month = mon_over ? 7'd1 : mon_inc[FIELD_W-1:0];
      if (mon_over) begin
        ticked.year = (fields.year >= YEAR_LAST) ? '0 : fields.year + 14'd1;
      end
    end
  end

  // Decode the command
  always_comb begin
    fields_next = fields;
    unique case (action)
      ACT_TICK: begin
        fields_next = ticked;
      end
      ACT_SET_TIME: begin
        fields_next.hour   = new_hour;
        fields_next.minute = new_minute;
        fields_next.second = new_second;
      end
      ACT_SET_DATE: begin
        fields_next.day   = new_day;
        fields_next.month = new_month;
        fields_next.year  = new_year;
      end
      default: begin
        fields_next = fields;
      end
    endcase
  end

  // Hold the current time and date
  always_ff @(posedge clk) begin
    if (rst) begin
      fields.hour   <= '0;
      fields.minute <= '0;
      fields.second <= '0;
      fields.day    <= 7'd1;
      fields.month  <= 7'd1;
      fields.year   <= RESET_YEAR;
    end else if (load) begin
      fields <= fields_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ccc_text.sv
// Eight-character display text: HH:MM:SS or DD.MM.YYYY with decimal points.
`default_nettype none
module ccc_text (
  input  wire ccc_pkg::clock_fields_t     fields,
  input  wire logic                       show_date,
  output logic [ccc_pkg::TEXT_W-1:0]      text
);
  import ccc_pkg::*;

  logic [YEAR_W-1:0] year_mod;
  logic [7:0]        year_hi;
  logic [YEAR_W-1:0] year_lo;
  logic [15:0]       hour_ch;
  logic [15:0]       min_ch;
  logic [15:0]       sec_ch;
  logic [15:0]       day_ch;
  logic [15:0]       mon_ch;
  logic [15:0]       yhi_ch;
  logic [15:0]       ylo_ch;

  // Split the year into century and year-of-century, both below 100
  always_comb begin
    year_mod = (fields.year >= YEAR_SPAN) ? fields.year - YEAR_SPAN : fields.year;
    year_hi  = div100(year_mod);
    year_lo  = year_mod - 14'(year_hi) * 14'd100;
  end

  // Convert each two-digit group to characters
  always_comb begin
    hour_ch = two_digits(fields.hour);
    min_ch  = two_digits(fields.minute);
    sec_ch  = two_digits(fields.second);
    day_ch  = two_digits(fields.day);
    mon_ch  = two_digits(fields.month);
    yhi_ch  = two_digits(year_hi[FIELD_W-1:0]);
    ylo_ch  = two_digits(year_lo[FIELD_W-1:0]);
  end

  // Select the time or date layout
  always_comb begin
    if (show_date) begin
      text = {day_ch[15:8], day_ch[7:0] + POINT_MARK,
              mon_ch[15:8], mon_ch[7:0] + POINT_MARK,
              yhi_ch, ylo_ch};
    end else begin
      text = {hour_ch, SEPARATOR, min_ch, SEPARATOR, sec_ch};
    end
  end

endmodule
`default_nettype wire

// File: rtl/clock_calendar_counter.sv
// Top level of the clock and calendar counter: handshake, state update and output register.
`default_nettype none
// Real-time clock and calendar. Each input word is a one-second tick, a set-time or a
// set-date command (set values load unchecked and do not tick); every word returns one
// result word with the time and date after it and an eight-character display text.
// Throughput is one word per clock while out_stall is low. The edge that takes an input
// word updates the time and date registers, and a later edge captures the formatted
// text into the output register. Those two stages give two words of buffering, so
// input is still taken while a finished result waits on out_stall. After reset the
// time is 00:00:00 on 1 January 1971.
module clock_calendar_counter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    action,
  input  wire logic                          show_date,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_hour,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_minute,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_second,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_day,
  input  wire logic [ccc_pkg::FIELD_W-1:0]   new_month,
  input  wire logic [ccc_pkg::YEAR_W-1:0]    new_year,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ccc_pkg::FIELD_W-1:0]        hour,
  output logic [ccc_pkg::FIELD_W-1:0]        minute,
  output logic [ccc_pkg::FIELD_W-1:0]        second,
  output logic [ccc_pkg::FIELD_W-1:0]        day,
  output logic [ccc_pkg::FIELD_W-1:0]        month,
  output logic [ccc_pkg::YEAR_W-1:0]         year,
  output logic [ccc_pkg::TEXT_W-1:0]         display_text
);
  import ccc_pkg::*;

  logic              in_accept;
  logic              stage_valid;
  logic              stage_show;
  logic              stage_move;
  clock_fields_t     cur;
  clock_fields_t     out_fields;
  logic [TEXT_W-1:0] text;

  // Handshake: stall only while the state stage is full and cannot drain
  assign stage_move = !out_valid || !out_stall;
  assign in_stall   = stage_valid && !stage_move;
  assign in_accept  = in_valid && !in_stall;

  ccc_calendar u_calendar (
    .clk        (clk),
    .rst        (rst),
    .load       (in_accept),
    .action     (action),
    .new_hour   (new_hour),
    .new_minute (new_minute),
    .new_second (new_second),
    .new_day    (new_day),
    .new_month  (new_month),
    .new_year   (new_year),
    .fields     (cur)
  );

  ccc_text u_text (
    .fields    (cur),
    .show_date (stage_show),
    .text      (text)
  );

  // Track the word sitting in the state stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_show <= show_date;
    end
  end

  // Advance the result word into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move && stage_valid) begin
      out_fields   <= cur;
      display_text <= text;
    end
  end

  assign hour   = out_fields.hour;
  assign minute = out_fields.minute;
  assign second = out_fields.second;
  assign day    = out_fields.day;
  assign month  = out_fields.month;
  assign year   = out_fields.year;

  // A taken word always occupies the state stage next cycle
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> stage_valid)
    else $error("accepted word did not reach the state stage");

  // The time and date only change when a word is taken
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(cur))
    else $error("time or date changed without an input word");

  // A tick leaves the seconds in range
  a_tick_second_range: assert property (@(posedge clk) disable iff (rst)
    (in_accept && action == ACT_TICK) |=> (cur.second < 7'd60))
    else $error("seconds out of range after a tick");

  // A tick moves the year only across the new year
  a_tick_year_step: assert property (@(posedge clk) disable iff (rst)
    (in_accept && action == ACT_TICK) |=>
      ((cur.year == $past(cur.year)) || (cur.month == 7'd1 && cur.day == 7'd1)))
    else $error("year changed on a tick outside the new year");

endmodule
`default_nettype wire

// File: bench/clock_calendar_counter_tb.sv
// Self-checking testbench for the clock and calendar counter: directed table, then random words.
`timescale 1ns / 1ps
module clock_calendar_counter_tb;
  import ccc_pkg::*;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         RANDOM_WORDS   = 1600;
  localparam int         WATCHDOG_LIMIT = 500;
  localparam int         END_SETTLE     = 8;
  localparam int         IDLE_MAX       = 11;

  // One result word as the block presents it
  typedef struct packed {
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [TEXT_W-1:0]  text;
  } calendar_word_t;

  // One input word, with an optional hand-written result
  typedef struct {
    logic [1:0]         act;
    logic               show;
    logic [FIELD_W-1:0] hour_in;
    logic [FIELD_W-1:0] minute_in;
    logic [FIELD_W-1:0] second_in;
    logic [FIELD_W-1:0] day_in;
    logic [FIELD_W-1:0] month_in;
    logic [YEAR_W-1:0]  year_in;
    bit                 checked;
    calendar_word_t     golden;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         action;
  logic               show_date;
  logic [FIELD_W-1:0] new_hour;
  logic [FIELD_W-1:0] new_minute;
  logic [FIELD_W-1:0] new_second;
  logic [FIELD_W-1:0] new_day;
  logic [FIELD_W-1:0] new_month;
  logic [YEAR_W-1:0]  new_year;
  logic               out_valid;
  logic               out_stall;
  logic [FIELD_W-1:0] hour;
  logic [FIELD_W-1:0] minute;
  logic [FIELD_W-1:0] second;
  logic [FIELD_W-1:0] day;
  logic [FIELD_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [TEXT_W-1:0]  display_text;

  // Hand-written result that travels with the word on the input channel
  bit             golden_armed;
  calendar_word_t golden_word;

  // Predicted clock and calendar
  int now_hour   = 0;
  int now_minute = 0;
  int now_second = 0;
  int now_day    = 1;
  int now_month  = 1;
  int now_year   = 1971;

  calendar_word_t pending_words[$];
  int             words_taken   = 0;
  int             words_checked = 0;
  int             quiet_cycles  = 0;
  int             mismatches    = 0;
  int             words_sent    = 0;
  bit             send_quiet    = 1'b0;

  clock_calendar_counter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .show_date    (show_date),
    .new_hour     (new_hour),
    .new_minute   (new_minute),
    .new_second   (new_second),
    .new_day      (new_day),
    .new_month    (new_month),
    .new_year     (new_year),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .day          (day),
    .month        (month),
    .year         (year),
    .display_text (display_text)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one word to the predicted calendar and return the result it gives
  function automatic calendar_word_t advance_calendar(input logic [1:0] act,
                                                      input logic show,
                                                      input logic [FIELD_W-1:0] h_in,
                                                      input logic [FIELD_W-1:0] mi_in,
                                                      input logic [FIELD_W-1:0] s_in,
                                                      input logic [FIELD_W-1:0] d_in,
                                                      input logic [FIELD_W-1:0] mo_in,
                                                      input logic [YEAR_W-1:0] y_in);
    calendar_word_t w;
    int             next_day;
    int             month_days;
    int             y4;
    bit             leap;
    case (act)
      ACT_TICK: begin
        // advance each stage on its own, so out-of-range values roll over too
        now_second = now_second + 1;
        if (now_second >= 60) begin
          now_second = 0;
          now_minute = now_minute + 1;
        end
        if (now_minute >= 60) begin
          now_minute = 0;
          now_hour = now_hour + 1;
        end
        if (now_hour >= 24) begin
          now_hour = 0;
          leap = ((now_year % 4 == 0) && (now_year % 100 != 0)) || (now_year % 400 == 0);
          case (now_month)
            1, 3, 5, 7, 8, 10, 12: month_days = 31;
            4, 6, 9, 11:           month_days = 30;
            2:                     month_days = leap ? 29 : 28;
            default:               month_days = 0;
          endcase
          next_day = now_day + 1;
          if (next_day > month_days) begin
            next_day = 1;
            now_month = now_month + 1;
          end
          if (now_month > 12) begin
            now_month = 1;
            now_year = (now_year >= 9999) ? 0 : now_year + 1;
          end
          now_day = next_day & 8'h7F;
          now_month = now_month & 8'h7F;
        end
      end
      ACT_SET_TIME: begin
        now_hour   = int'(h_in);
        now_minute = int'(mi_in);
        now_second = int'(s_in);
      end
      ACT_SET_DATE: begin
        now_day   = int'(d_in);
        now_month = int'(mo_in);
        now_year  = int'(y_in);
      end
      default: ;
    endcase
    w.hour   = 7'(now_hour);
    w.minute = 7'(now_minute);
    w.second = 7'(now_second);
    w.day    = 7'(now_day);
    w.month  = 7'(now_month);
    w.year   = 14'(now_year);
    y4 = now_year % 10000;
    if (show) begin
      w.text = {8'(now_day / 10 + ASCII_ZERO), 8'(now_day % 10 + ASCII_ZERO + POINT_MARK),
                8'(now_month / 10 + ASCII_ZERO),
                8'(now_month % 10 + ASCII_ZERO + POINT_MARK),
                8'(y4 / 1000 + ASCII_ZERO), 8'((y4 / 100) % 10 + ASCII_ZERO),
                8'((y4 / 10) % 10 + ASCII_ZERO), 8'(y4 % 10 + ASCII_ZERO)};
    end else begin
      w.text = {8'(now_hour / 10 + ASCII_ZERO), 8'(now_hour % 10 + ASCII_ZERO), SEPARATOR,
                8'(now_minute / 10 + ASCII_ZERO), 8'(now_minute % 10 + ASCII_ZERO), SEPARATOR,
                8'(now_second / 10 + ASCII_ZERO), 8'(now_second % 10 + ASCII_ZERO)};
    end
    return w;
  endfunction

  function automatic stim_row_t mk_row(input logic [1:0] act, input logic show,
                                       input int h, input int mi, input int s,
                                       input int d, input int mo, input int y);
    stim_row_t r;
    r.act       = act;
    r.show      = show;
    r.hour_in   = 7'(h);
    r.minute_in = 7'(mi);
    r.second_in = 7'(s);
    r.day_in    = 7'(d);
    r.month_in  = 7'(mo);
    r.year_in   = 14'(y);
    r.checked   = 1'b0;
    r.golden    = '0;
    return r;
  endfunction

  function automatic stim_row_t with_golden(input stim_row_t r, input int h, input int mi,
                                            input int s, input int d, input int mo,
                                            input int y, input logic [TEXT_W-1:0] txt);
    stim_row_t g;
    g = r;
    g.checked = 1'b1;
    g.golden  = '{hour: 7'(h), minute: 7'(mi), second: 7'(s), day: 7'(d),
                  month: 7'(mo), year: 14'(y), text: txt};
    return g;
  endfunction

  // Word with every field drawn over its full width
  function automatic stim_row_t rand_row(input logic [1:0] act);
    return mk_row(act, 1'($urandom_range(0, 1)), $urandom_range(0, 127),
                  $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 127), $urandom_range(0, 16383));
  endfunction

  // Present one word after a random gap and hold it until taken
  task automatic send_word(input stim_row_t r);
    int gap;
    if (words_sent % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    words_sent++;
    gap = send_quiet ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= r.act;
    show_date    <= r.show;
    new_hour     <= r.hour_in;
    new_minute   <= r.minute_in;
    new_second   <= r.second_in;
    new_day      <= r.day_in;
    new_month    <= r.month_in;
    new_year     <= r.year_in;
    golden_armed <= r.checked;
    golden_word  <= r.golden;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the input until every outstanding result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_checked != words_taken) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [TEXT_W-1:0] want,
                             input logic [TEXT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Predict on every input word taken, compare on every result word taken
  always @(posedge clk) begin : watch_words
    calendar_word_t want;
    calendar_word_t got;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        want = advance_calendar(action, show_date, new_hour, new_minute, new_second,
                                new_day, new_month, new_year);
        if (golden_armed) want = golden_word;
        pending_words.push_back(want);
        words_taken <= words_taken + 1;
      end
      if (out_valid && !out_stall) begin
        got = '{hour: hour, minute: minute, second: second, day: day, month: month,
                year: year, text: display_text};
        if (pending_words.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual %0h",
                   $time, got);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          check_field("hour", TEXT_W'(want.hour), TEXT_W'(got.hour));
          check_field("minute", TEXT_W'(want.minute), TEXT_W'(got.minute));
          check_field("second", TEXT_W'(want.second), TEXT_W'(got.second));
          check_field("day", TEXT_W'(want.day), TEXT_W'(got.day));
          check_field("month", TEXT_W'(want.month), TEXT_W'(got.month));
          check_field("year", TEXT_W'(want.year), TEXT_W'(got.year));
          check_field("display_text", want.text, got.text);
        end
        words_checked <= words_checked + 1;
      end
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                      0 : quiet_cycles + 1;
    end
  end

  // Result side: stall for a random number of cycles before each word
  initial begin : drain_results
    int hold;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (taken % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      hold = quiet ? 0 : $urandom_range(0, IDLE_MAX);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : run_stimulus
    stim_row_t directed_rows[$];
    stim_row_t seq[$];
    stim_row_t r;
    int        random_words;
    int        kind;
    int        n;
    int        pick;
    bit        paused;
    random_words = 0;
    paused       = 1'b0;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    action       <= ACT_TICK;
    show_date    <= 1'b0;
    new_hour     <= '0;
    new_minute   <= '0;
    new_second   <= '0;
    new_day      <= '0;
    new_month    <= '0;
    new_year     <= '0;
    golden_armed <= 1'b0;
    golden_word  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table: reset values, unused code, extremes, wraps, leap rules
    directed_rows.push_back(with_golden(mk_row(ACT_TICK, 1'b0, 0, 0, 0, 0, 0, 0),
                                        0, 0, 1, 1, 1, 1971, 64'h30303A30303A3031));
    directed_rows.push_back(with_golden(mk_row(ACT_TICK, 1'b1, 0, 0, 0, 0, 0, 0),
                                        0, 0, 2, 1, 1, 1971, 64'h30B130B131393731));
    directed_rows.push_back(with_golden(mk_row(ACT_UNUSED, 1'b0, 9, 9, 9, 9, 9, 9),
                                        0, 0, 2, 1, 1, 1971, 64'h30303A30303A3032));
    directed_rows.push_back(with_golden(mk_row(ACT_SET_TIME, 1'b0, 23, 59, 59, 0, 0, 0),
                                        23, 59, 59, 1, 1, 1971, 64'h32333A35393A3539));
    directed_rows.push_back(with_golden(mk_row(ACT_SET_DATE, 1'b1, 0, 0, 0, 31, 12, 9999),
                                        23, 59, 59, 31, 12, 9999, 64'h33B131B239393939));
    directed_rows.push_back(with_golden(mk_row(ACT_TICK, 1'b1, 0, 0, 0, 0, 0, 0),
                                        0, 0, 0, 1, 1, 0, 64'h30B130B130303030));
    directed_rows.push_back(with_golden(mk_row(ACT_SET_TIME, 1'b0, 127, 127, 127, 0, 0, 0),
                                        127, 127, 127, 1, 1, 0, 64'h3C373A3C373A3C37));
    directed_rows.push_back(mk_row(ACT_TICK, 1'b1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(with_golden(mk_row(ACT_SET_DATE, 1'b1, 0, 0, 0, 127, 127, 16383),
                                        0, 0, 0, 127, 127, 16383, 64'h3CB73CB736333833));
    directed_rows.push_back(mk_row(ACT_SET_TIME, 1'b0, 23, 59, 59, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_TICK, 1'b1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(with_golden(mk_row(ACT_SET_DATE, 1'b1, 0, 0, 0, 0, 0, 0),
                                        0, 0, 0, 0, 0, 0, 64'h30B030B030303030));
    directed_rows.push_back(with_golden(mk_row(ACT_SET_TIME, 1'b0, 0, 0, 0, 0, 0, 0),
                                        0, 0, 0, 0, 0, 0, 64'h30303A30303A3030));
    directed_rows.push_back(mk_row(ACT_SET_TIME, 1'b0, 5, 75, 10, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_TICK, 1'b0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_SET_TIME, 1'b0, 10, 20, 99, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_TICK, 1'b0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_SET_DATE, 1'b1, 0, 0, 0, 28, 2, 2000));
    directed_rows.push_back(mk_row(ACT_SET_TIME, 1'b0, 23, 59, 59, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_TICK, 1'b1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_SET_DATE, 1'b1, 0, 0, 0, 28, 2, 1900));
    directed_rows.push_back(mk_row(ACT_SET_TIME, 1'b0, 23, 59, 59, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_TICK, 1'b1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_SET_DATE, 1'b1, 0, 0, 0, 30, 4, 2023));
    directed_rows.push_back(mk_row(ACT_SET_TIME, 1'b0, 23, 59, 59, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_TICK, 1'b1, 0, 0, 0, 0, 0, 0));
    foreach (directed_rows[i]) send_word(directed_rows[i]);
    wait_for_results();

    // Random part: mostly month-end rollovers, with runs of ticks and some noise
    while (random_words < RANDOM_WORDS) begin
      seq.delete();
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        r = rand_row(ACT_SET_DATE);
        r.day_in   = 7'($urandom_range(27, 31));
        r.month_in = 7'($urandom_range(1, 12));
        pick = $urandom_range(0, 4);
        case (pick)
          0:       r.year_in = 14'($urandom_range(0, 9999));
          1:       r.year_in = 14'(4 * $urandom_range(0, 2499));
          2:       r.year_in = 14'(100 * $urandom_range(0, 99));
          3:       r.year_in = 14'(400 * $urandom_range(0, 24));
          default: r.year_in = 14'd9999;
        endcase
        seq.push_back(r);
        r = rand_row(ACT_SET_TIME);
        r.hour_in   = 7'd23;
        r.minute_in = 7'd59;
        r.second_in = 7'($urandom_range(50, 59));
        seq.push_back(r);
        n = $urandom_range(1, 12);
        repeat (n) seq.push_back(rand_row(ACT_TICK));
      end else if (kind < 70) begin
        n = $urandom_range(1, 20);
        repeat (n) seq.push_back(rand_row(ACT_TICK));
      end else if (kind < 80) begin
        r = rand_row(ACT_SET_TIME);
        r.hour_in   = 7'($urandom_range(0, 23));
        r.minute_in = 7'($urandom_range(0, 59));
        r.second_in = 7'($urandom_range(0, 59));
        seq.push_back(r);
        n = $urandom_range(1, 4);
        repeat (n) seq.push_back(rand_row(ACT_TICK));
      end else if (kind < 92) begin
        seq.push_back(rand_row($urandom_range(0, 1) ? ACT_SET_TIME : ACT_SET_DATE));
        n = $urandom_range(1, 4);
        repeat (n) seq.push_back(rand_row(ACT_TICK));
      end else begin
        seq.push_back(rand_row(ACT_UNUSED));
      end
      foreach (seq[i]) begin
        send_word(seq[i]);
        if (seq[i].act != ACT_UNUSED) random_words++;
      end
      if (!paused && random_words >= RANDOM_WORDS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end

    // Drain, settle, then report
    wait_for_results();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_words.size() != 0) begin
      $display("%0t: %0d result words still expected, expected 0, actual %0d",
               $time, pending_words.size(), pending_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
